FILE: src/sfrx_pkg.sv
// Shared types, constants and decode helpers for the serial frame receiver.
package sfrx_pkg;

  // Item kinds on the input channel
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Frame framing bytes
  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] FOOTER_BYTE = 8'h55;

  // Register reset and tick counter ceiling
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam int          TICK_W        = 17;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // Frame byte positions
  localparam int IDX_SRC    = 1;
  localparam int IDX_DEST   = 2;
  localparam int IDX_OP     = 3;
  localparam int IDX_ADDR   = 4;
  localparam int IDX_LEN    = 5;
  localparam int IDX_POS_HI = 6;
  localparam int IDX_POS_LO = 7;
  localparam int PAY_BASE   = 6;

  // Header + five fixed fields + check + footer
  localparam int FRAME_OVERHEAD = 8;
  localparam int EXP_W          = 9;

  // Opcodes with a decoded action
  localparam logic [7:0] OP_FIRST   = 8'h01;
  localparam logic [7:0] OP_LAST    = 8'h08;
  localparam logic [7:0] OP_FIRE    = 8'h53;
  localparam logic [7:0] OP_SET_MIN = 8'h54;
  localparam logic [7:0] OP_SET_MAX = 8'h55;

  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_FIRE    = 4'd9;
  localparam logic [3:0] ACT_SET_MIN = 4'd10;
  localparam logic [3:0] ACT_SET_MAX = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_READ,
    ST_SHOW
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic hdr_start;
    logic store;
    logic tick;
    logic emit_start;
    logic rd_en;
    logic emit_next;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_header;
    logic late;
    logic full;
    logic done;
    logic good;
    logic last_item;
  } dp_sts_t;

  function automatic logic [3:0] decode_action(input logic [7:0] op);
    logic [3:0] act;
    act = ACT_NONE;
    if (op >= OP_FIRST && op <= OP_LAST) begin
      act = op[3:0];
    end else if (op == OP_FIRE) begin
      act = ACT_FIRE;
    end else if (op == OP_SET_MIN) begin
      act = ACT_SET_MIN;
    end else if (op == OP_SET_MAX) begin
      act = ACT_SET_MAX;
    end
    return act;
  endfunction

endpackage

FILE: src/sfrx_ctrl.sv
// Controller state machine: frame reception, drop decisions and result sequencing.
module sfrx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic              out_stall,
  input  sfrx_pkg::dp_sts_t sts,
  output sfrx_pkg::dp_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import sfrx_pkg::*;

  state_t state_r, state_nxt;
  logic   byte_in;
  logic   tick_in;

  assign byte_in = in_valid && (in_cmd == CMD_BYTE);
  assign tick_in = in_valid && (in_cmd == CMD_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (byte_in && sts.is_header) state_nxt = ST_RECV;
      end
      ST_RECV: begin
        if (byte_in) begin
          if (sts.late || sts.full) begin
            state_nxt = ST_IDLE;
          end else if (sts.done) begin
            state_nxt = sts.good ? ST_READ : ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall) state_nxt = sts.last_item ? ST_IDLE : ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.hdr_start = byte_in && sts.is_header;
      end
      ST_RECV: begin
        cmd.tick = tick_in;
        if (byte_in && !sts.late && !sts.full) begin
          cmd.store      = 1'b1;
          cmd.emit_start = sts.done && sts.good;
        end
      end
      ST_READ: begin
        in_stall  = 1'b1;
        cmd.rd_en = 1'b1;
      end
      ST_SHOW: begin
        in_stall      = 1'b1;
        out_valid     = 1'b1;
        cmd.emit_next = !out_stall && !sts.last_item;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/sfrx_dp.sv
// Datapath: frame store, header field registers, tick counter and XOR check.
module sfrx_dp #(
  parameter int MAX_FRAME = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfrx_pkg::dp_cmd_t cmd,
  output sfrx_pkg::dp_sts_t sts,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output logic [7:0]        src_id,
  output logic [7:0]        dest_id,
  output logic [7:0]        opcode,
  output logic [7:0]        reg_addr,
  output logic [5:0]        payload_length,
  output logic [3:0]        action,
  output logic [15:0]       position,
  output logic [7:0]        payload_byte,
  output logic [5:0]        payload_index,
  output logic              has_payload,
  output logic              last
);
  import sfrx_pkg::*;

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [7:0]        mem [MAX_FRAME];
  logic [15:0]       timeout_r;
  logic [CW-1:0]     count_r;
  logic [EXP_W-1:0]  expected_len_r;
  logic [TICK_W-1:0] elapsed_r;
  logic [7:0]        xor_r;
  logic [7:0]        src_r, dest_r, op_r, addr_r, plen_r, pos_hi_r, pos_lo_r;
  logic [5:0]        k_r;
  logic [7:0]        rd_data_r;
  logic [6:0]        rd_sum;
  logic [AW-1:0]     rd_addr;
  logic              empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      elapsed_r <= '0;
    end else if (cmd.hdr_start) begin
      count_r   <= CW'(1);
      elapsed_r <= '0;
    end else begin
      if (cmd.store) count_r <= count_r + CW'(1);
      if (cmd.tick && elapsed_r != TICK_MAX) elapsed_r <= elapsed_r + TICK_W'(1);
    end
  end

  // Running XOR over frame bytes from source on; header byte is never stored
  always_ff @(posedge clk) begin
    if (cmd.hdr_start) begin
      xor_r <= '0;
    end else if (cmd.store) begin
      xor_r <= xor_r ^ rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count_r[AW-1:0]] <= rx_byte;
      case (count_r)
        CW'(IDX_SRC):    src_r    <= rx_byte;
        CW'(IDX_DEST):   dest_r   <= rx_byte;
        CW'(IDX_OP):     op_r     <= rx_byte;
        CW'(IDX_ADDR):   addr_r   <= rx_byte;
        CW'(IDX_LEN): begin
          plen_r         <= rx_byte;
          expected_len_r <= EXP_W'(FRAME_OVERHEAD) + {1'b0, rx_byte};
        end
        CW'(IDX_POS_HI): pos_hi_r <= rx_byte;
        CW'(IDX_POS_LO): pos_lo_r <= rx_byte;
        default: ;
      endcase
    end
  end

  // Emission index and registered store read
  assign rd_sum  = {1'b0, k_r} + 7'(PAY_BASE);
  assign rd_addr = rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      k_r <= '0;
    end else if (cmd.emit_next) begin
      k_r <= k_r + 6'd1;
    end
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  assign empty = (plen_r == 8'd0);

  always_comb begin
    sts.is_header = (rx_byte == HEADER_BYTE);
    sts.late      = (elapsed_r > {1'b0, timeout_r});
    sts.full      = (count_r >= CW'(MAX_FRAME));
    sts.done      = (count_r >= CW'(IDX_POS_HI)) &&
                    ((EXP_W'(count_r) + EXP_W'(1)) == expected_len_r);
    sts.good      = (rx_byte == FOOTER_BYTE) && (xor_r == 8'd0);
    sts.last_item = empty || ((8'(k_r) + 8'd1) == plen_r);
  end

  assign src_id         = src_r;
  assign dest_id        = dest_r;
  assign opcode         = op_r;
  assign reg_addr       = addr_r;
  assign payload_length = plen_r[5:0];
  assign action         = decode_action(op_r);
  assign position       = {pos_hi_r, pos_lo_r};
  assign payload_byte   = empty ? 8'd0 : rd_data_r;
  assign payload_index  = empty ? 6'd0 : k_r;
  assign has_payload    = !empty;
  assign last           = sts.last_item;

endmodule

FILE: src/serial_frame_receiver_xor_check_unit.sv
// Top level of the serial frame receiver with XOR check.
// Each input request is either a received byte or one timer tick, and is taken
// without stall while a frame is being collected. A byte of 0xAA opens a
// frame: source, destination, opcode, address, payload length, payload, XOR
// check byte and 0x55 footer follow. A byte that arrives after more ticks since
// the header than the timeout register holds, or once MAX_FRAME frame bytes
// (header included) are in, drops itself and the frame. A complete frame with a
// good footer and XOR is sent out as one result request per payload byte (a
// single result when the payload is empty). During that phase the input is
// stalled; each result takes a frame store read and then its presentation,
// which is held while the output is stalled. The frame store keeps no reset or
// valid bits: only entries written by the current frame are ever read.
module serial_frame_receiver_xor_check_unit #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  // Result requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_src_id,
  output logic [7:0]  out_dest_id,
  output logic [7:0]  out_opcode,
  output logic [7:0]  out_reg_addr,
  output logic [5:0]  out_payload_length,
  output logic [3:0]  out_action,
  output logic [15:0] out_position,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_payload_index,
  output logic        out_has_payload,
  output logic        out_last,
  // Timeout register write
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import sfrx_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence reception, drop decisions and result hand-off
  sfrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Hold the frame, tick count, XOR and result fields
  sfrx_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .rx_byte        (in_rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .src_id         (out_src_id),
    .dest_id        (out_dest_id),
    .opcode         (out_opcode),
    .reg_addr       (out_reg_addr),
    .payload_length (out_payload_length),
    .action         (out_action),
    .position       (out_position),
    .payload_byte   (out_payload_byte),
    .payload_index  (out_payload_index),
    .has_payload    (out_has_payload),
    .last           (out_last)
  );

`ifndef ASSERT_OFF
  // No input may be taken while a result is on offer
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during result emission");

  // An empty-payload result is marked last, so an empty payload gives a single result
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_payload) |-> out_last)
    else $error("empty-payload result not marked last");

  // Payload index stays inside the announced payload length
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_payload) |-> (out_payload_index < out_payload_length))
    else $error("payload index beyond payload length");

  // Last result taken ends the frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> !out_valid)
    else $error("result offered after last one was taken");
`endif

endmodule

FILE: sim/tb.sv
// Testbench for the serial frame receiver: directed frame script, then random frame traffic.
`timescale 1ns / 1ps

module tb;
  import sfrx_pkg::*;

  // Frame store depth of the unit under test
  localparam int FRAME_CAP = 64;
  localparam int MEM_AW = $clog2(FRAME_CAP);
  // Largest payload that still fits the store (header, fields, check, footer)
  localparam int MAX_PAYLOAD = FRAME_CAP - FRAME_OVERHEAD;
  // Frame bytes to send in the random part, spread over the timeout phases
  localparam int RANDOM_ITEMS = 500;
  localparam int NUM_PHASES = 4;
  // Cycles to let pass once nothing is pending: before a timeout write and at the end
  localparam int SETTLE_CYCLES = 16;
  // Safety net against a hung run
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_PRINTS = 40;

  // One result request, laid out as on the output ports
  typedef struct packed {
    logic [7:0]  src_id;
    logic [7:0]  dest_id;
    logic [7:0]  opcode;
    logic [7:0]  reg_addr;
    logic [5:0]  payload_length;
    logic [3:0]  action;
    logic [15:0] position;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic        has_payload;
    logic        last;
  } frame_result_t;

  // Ways a frame can be broken on purpose
  typedef enum logic [1:0] {
    FL_NONE,
    FL_XOR,
    FL_FOOTER,
    FL_LATE
  } frame_flaw_t;

  // Kinds of row in the directed script
  typedef enum logic [1:0] {
    RK_FRAME,
    RK_BYTE,
    RK_TICKS,
    RK_CFG
  } row_kind_t;

  // One directed row. RK_BYTE sends src as a lone byte; RK_TICKS and RK_CFG take
  // tick_n as tick count or timeout value. exp_cnt -1 leaves the results to the
  // frame tracker; 0 means the row must produce nothing; 1 means a single
  // empty-payload result whose action and position are typed in the row.
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  src;
    logic [7:0]  dest;
    logic [7:0]  op;
    logic [7:0]  addr;
    logic [7:0]  len;
    frame_flaw_t flaw;
    int          tick_pos;
    int          tick_n;
    int          exp_cnt;
    logic [3:0]  act;
    logic [15:0] pos;
  } row_t;

  localparam int NUM_ROWS = 32;

  // Empty frames with src == dest and op == addr have a zero check byte, so their
  // position reads {00, footer} straight off the row.
  localparam row_t SCRIPT [NUM_ROWS] = '{
    // idle noise: ticks and non-header bytes are ignored
    '{RK_TICKS, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 5, 0, ACT_NONE, 16'h0000},
    '{RK_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 0, 0, ACT_NONE, 16'h0000},
    '{RK_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 0, 0, ACT_NONE, 16'h0000},
    // empty payload, one result each, every named action
    '{RK_FRAME, 8'h00, 8'h00, OP_FIRE, 8'h53, 8'd0, FL_NONE, 0, 0, 1, ACT_FIRE, 16'h0055},
    '{RK_FRAME, 8'hFF, 8'hFF, OP_SET_MIN, 8'h54, 8'd0, FL_NONE, 0, 0, 1, ACT_SET_MIN,
      16'h0055},
    '{RK_FRAME, 8'h12, 8'h12, OP_SET_MAX, 8'h55, 8'd0, FL_NONE, 0, 0, 1, ACT_SET_MAX,
      16'h0055},
    '{RK_FRAME, 8'hA5, 8'hA5, OP_FIRST, 8'h01, 8'd0, FL_NONE, 0, 0, 1, 4'd1, 16'h0055},
    '{RK_FRAME, 8'h3C, 8'h3C, OP_LAST, 8'h08, 8'd0, FL_NONE, 0, 0, 1, 4'd8, 16'h0055},
    '{RK_FRAME, 8'h07, 8'h07, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 0, 1, ACT_NONE, 16'h0055},
    // payload frames; one-byte payloads read the check byte into the low half of position
    '{RK_FRAME, 8'h11, 8'h22, 8'h02, 8'h33, 8'd1, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h80, 8'h01, 8'h03, 8'hFE, 8'd2, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h5A, 8'hC3, 8'h04, 8'h7F, 8'd3, FL_NONE, 4, 500, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h01, 8'h02, 8'h05, 8'h04, 8'd7, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'hFF, 8'h00, 8'h06, 8'hFF, 8'd56, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h33, 8'h44, 8'h07, 8'h55, 8'd5, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h66, 8'h77, 8'h09, 8'h88, 8'd4, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h99, 8'hAA, 8'h51, 8'hBB, 8'd1, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'hCC, 8'hDD, 8'h52, 8'hEE, 8'd1, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h0F, 8'hF0, 8'hFF, 8'h00, 8'd2, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    // broken frames, dropped silently
    '{RK_FRAME, 8'h40, 8'h41, 8'h03, 8'h42, 8'd3, FL_XOR, 0, 0, 0, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h40, 8'h41, 8'h03, 8'h42, 8'd0, FL_FOOTER, 0, 0, 0, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h01, 8'h01, 8'h01, 8'h01, 8'd57, FL_NONE, 0, 0, 0, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h01, 8'h01, 8'h01, 8'h01, 8'd255, FL_NONE, 0, 0, 0, ACT_NONE, 16'h0},
    // late header-valued byte is dropped, not taken as a fresh header
    '{RK_FRAME, 8'hAA, 8'h10, 8'h02, 8'h03, 8'd0, FL_LATE, 1, 501, 0, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h21, 8'h43, 8'h06, 8'h65, 8'd2, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    // zero timeout: no tick allowed once the header is in
    '{RK_CFG, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 0, 0, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h10, 8'h20, 8'h01, 8'h30, 8'd1, FL_NONE, 0, 0, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'h10, 8'h20, 8'h01, 8'h30, 8'd4, FL_LATE, 7, 1, 0, ACT_NONE, 16'h0},
    // widest timeout, met exactly, then a tick run past counter saturation
    '{RK_CFG, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 65535, 0, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'hE1, 8'hE2, 8'h08, 8'hE3, 8'd2, FL_NONE, 6, 65535, -1, ACT_NONE, 16'h0},
    '{RK_FRAME, 8'hE1, 8'hE2, 8'h08, 8'hE3, 8'd2, FL_LATE, 2, 140000, 0, ACT_NONE, 16'h0},
    '{RK_CFG, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, FL_NONE, 0, 500, 0, ACT_NONE, 16'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_src_id;
  logic [7:0]  out_dest_id;
  logic [7:0]  out_opcode;
  logic [7:0]  out_reg_addr;
  logic [5:0]  out_payload_length;
  logic [3:0]  out_action;
  logic [15:0] out_position;
  logic [7:0]  out_payload_byte;
  logic [5:0]  out_payload_index;
  logic        out_has_payload;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  // Own copy of the receiver: timeout register, frame progress and frame store
  logic [15:0]       timeout_reg = TIMEOUT_RESET;
  logic              rx_active = 1'b0;
  logic [6:0]        byte_cnt = '0;
  logic [EXP_W-1:0]  frame_len = '0;
  logic [TICK_W-1:0] tick_cnt = '0;
  logic [7:0]        frame_mem [FRAME_CAP];

  frame_result_t pending_results [$];
  bit            record_predictions = 1'b1;
  bit            in_gaps = 1'b1;
  bit            out_gaps = 1'b1;
  int            error_count = 0;
  int            cycle_count = 0;
  int            frame_items = 0;

  serial_frame_receiver_xor_check_unit #(
    .MAX_FRAME(FRAME_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_src_id(out_src_id),
    .out_dest_id(out_dest_id),
    .out_opcode(out_opcode),
    .out_reg_addr(out_reg_addr),
    .out_payload_length(out_payload_length),
    .out_action(out_action),
    .out_position(out_position),
    .out_payload_byte(out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_has_payload(out_has_payload),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Print one line per mismatch (up to a cap) and count every one
  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // Drop the frame in progress and go back to hunting for a header
  task automatic abandon_frame();
    rx_active = 1'b0;
    byte_cnt  = '0;
    tick_cnt  = '0;
  endtask

  // Advance the tracked receiver by one accepted request and queue any results
  // that a completed, well-formed frame releases.
  task automatic track_receiver(input logic cmd, input logic [7:0] b);
    logic [7:0]    sum;
    logic [7:0]    plen;
    logic [7:0]    op;
    logic [3:0]    act;
    int            n;
    frame_result_t r;
    if (cmd == CMD_TICK) begin
      // ticks only count while a frame is open, and stick at the ceiling
      if (rx_active && tick_cnt != TICK_MAX) begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end else if (!rx_active) begin
      if (b == HEADER_BYTE) begin
        frame_mem[0] = b;
        byte_cnt     = 7'd1;
        tick_cnt     = '0;
        rx_active    = 1'b1;
      end
    end else if (tick_cnt > {1'b0, timeout_reg}) begin
      // late byte: drop it along with the frame
      abandon_frame();
    end else if (byte_cnt >= FRAME_CAP) begin
      // store full: drop the byte and the frame
      abandon_frame();
    end else begin
      frame_mem[byte_cnt[MEM_AW-1:0]] = b;
      byte_cnt = byte_cnt + 1'b1;
      if (byte_cnt == PAY_BASE) begin
        frame_len = EXP_W'(FRAME_OVERHEAD + frame_mem[IDX_LEN]);
      end
      if (byte_cnt >= PAY_BASE && byte_cnt == frame_len) begin
        if (frame_mem[frame_len - 1] == FOOTER_BYTE) begin
          sum = '0;
          for (int i = 1; i < frame_len - 2; i++) begin
            sum ^= frame_mem[i];
          end
          if (sum == frame_mem[frame_len - 2] && record_predictions) begin
            plen = frame_mem[IDX_LEN];
            op   = frame_mem[IDX_OP];
            n    = (plen == 0) ? 1 : plen;
            if (op >= OP_FIRST && op <= OP_LAST) begin
              act = op[3:0];
            end else begin
              case (op)
                OP_FIRE:    act = ACT_FIRE;
                OP_SET_MIN: act = ACT_SET_MIN;
                OP_SET_MAX: act = ACT_SET_MAX;
                default:    act = ACT_NONE;
              endcase
            end
            for (int k = 0; k < n; k++) begin
              r.src_id         = frame_mem[IDX_SRC];
              r.dest_id        = frame_mem[IDX_DEST];
              r.opcode         = op;
              r.reg_addr       = frame_mem[IDX_ADDR];
              r.payload_length = plen[5:0];
              r.action         = act;
              r.position       = {frame_mem[IDX_POS_HI], frame_mem[IDX_POS_LO]};
              if (plen == 0) begin
                r.payload_byte  = '0;
                r.payload_index = '0;
                r.has_payload   = 1'b0;
              end else begin
                r.payload_byte  = frame_mem[PAY_BASE + k];
                r.payload_index = 6'(k);
                r.has_payload   = 1'b1;
              end
              r.last = (k == n - 1);
              pending_results.insert(pending_results.size(), r);
            end
          end
        end
        abandon_frame();
      end
    end
  endtask

  // Hand one request to the unit: at random leave valid low first, then hold valid and
  // payload until the request is taken.
  task automatic push_request(input logic cmd, input logic [7:0] b);
    if (in_gaps && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    track_receiver(cmd, b);
  endtask

  // Build a frame with a random payload and send it. Ticks go in ahead of byte
  // tick_pos. A late frame stops at the byte that trips the timeout; an
  // overlong one stops at the first byte that no longer fits the store.
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dest,
                            input logic [7:0] op, input logic [7:0] addr,
                            input logic [7:0] len, input frame_flaw_t flaw,
                            input int tick_pos, input int tick_n);
    logic [7:0] fb [$];
    logic [7:0] chk;
    logic [7:0] tail;
    int         sent;
    fb = {HEADER_BYTE, src, dest, op, addr, len};
    for (int i = 0; i < len; i++) begin
      fb.insert(fb.size(), 8'($urandom_range(0, 255)));
    end
    chk = '0;
    for (int i = 1; i < fb.size(); i++) begin
      chk ^= fb[i];
    end
    if (flaw == FL_XOR) begin
      chk ^= 8'h01 << $urandom_range(0, 7);
    end
    fb.insert(fb.size(), chk);
    tail = FOOTER_BYTE;
    if (flaw == FL_FOOTER) begin
      tail = 8'($urandom_range(0, 255));
      if (tail == FOOTER_BYTE) begin
        tail = ~tail;
      end
    end
    fb.insert(fb.size(), tail);
    sent = (fb.size() > FRAME_CAP) ? FRAME_CAP + 1 : fb.size();
    if (flaw == FL_LATE) begin
      sent = tick_pos + 1;
    end
    for (int i = 0; i < sent; i++) begin
      if (i == tick_pos) begin
        repeat (tick_n) push_request(CMD_TICK, 8'($urandom_range(0, 255)));
      end
      push_request(CMD_BYTE, fb[i]);
    end
    frame_items += sent;
  endtask

  // Write the timeout only once the unit is quiet: no request offered, every
  // expected result in, and a settle wait for a frame that gave none.
  task automatic set_timeout(input logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_reg = value;
  endtask

  // Stall the result side at random, except in the stretch without gaps
  always @(posedge clk) begin
    out_stall <= out_gaps && ($urandom_range(0, 99) < 10);
  end

  // Compare every taken result request with the oldest expectation
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result src %h index %0d last %b",
                                out_src_id, out_payload_index, out_last));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("src_id", out_src_id, want.src_id);
        check_field("dest_id", out_dest_id, want.dest_id);
        check_field("opcode", out_opcode, want.opcode);
        check_field("reg_addr", out_reg_addr, want.reg_addr);
        check_field("payload_length", out_payload_length, want.payload_length);
        check_field("action", out_action, want.action);
        check_field("position", out_position, want.position);
        check_field("payload_byte", out_payload_byte, want.payload_byte);
        check_field("payload_index", out_payload_index, want.payload_index);
        check_field("has_payload", out_has_payload, want.has_payload);
        check_field("last", out_last, want.last);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    row_t          row;
    frame_result_t typed;
    logic [15:0]   phase_timeout [NUM_PHASES];
    logic [7:0]    r_len;
    logic [7:0]    r_op;
    logic [7:0]    noise;
    frame_flaw_t   flaw;
    int            pick;
    int            span;
    int            tp;
    int            tn;
    int            goal;

    // Hold reset, then release it once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = SCRIPT[i];
      record_predictions = (row.exp_cnt < 0);
      case (row.kind)
        RK_BYTE:  push_request(CMD_BYTE, row.src);
        RK_TICKS: repeat (row.tick_n) push_request(CMD_TICK, 8'($urandom_range(0, 255)));
        RK_CFG:   set_timeout(16'(row.tick_n));
        default: begin
          send_frame(row.src, row.dest, row.op, row.addr, row.len, row.flaw,
                     row.tick_pos, row.tick_n);
        end
      endcase
      // Queue the hand-written result right after the footer request is taken
      if (row.exp_cnt == 1) begin
        typed.src_id         = row.src;
        typed.dest_id        = row.dest;
        typed.opcode         = row.op;
        typed.reg_addr       = row.addr;
        typed.payload_length = '0;
        typed.action         = row.act;
        typed.position       = row.pos;
        typed.payload_byte   = '0;
        typed.payload_index  = '0;
        typed.has_payload    = 1'b0;
        typed.last           = 1'b1;
        pending_results.insert(pending_results.size(), typed);
      end
      record_predictions = 1'b1;
    end

    // Random frames under several timeouts; the third phase runs without gaps
    phase_timeout[0] = 16'($urandom_range(1, 40));
    phase_timeout[1] = 16'd0;
    phase_timeout[2] = 16'hFFFF;
    phase_timeout[3] = TIMEOUT_RESET;
    goal = frame_items;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_timeout(phase_timeout[phase]);
      in_gaps  = (phase != 2);
      out_gaps = (phase != 2);
      goal += RANDOM_ITEMS / NUM_PHASES;
      while (frame_items < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          r_len = 8'($urandom_range(0, 8));
        end else if (pick < 95) begin
          r_len = 8'($urandom_range(9, MAX_PAYLOAD));
        end else begin
          r_len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          r_op = 8'($urandom_range(OP_FIRST, OP_LAST));
        end else if (pick < 80) begin
          case ($urandom_range(0, 7))
            0: r_op = 8'h00;
            1: r_op = 8'h09;
            2: r_op = 8'h51;
            3: r_op = 8'h52;
            4: r_op = OP_FIRE;
            5: r_op = OP_SET_MIN;
            6: r_op = OP_SET_MAX;
            default: r_op = HEADER_BYTE;
          endcase
        end else begin
          r_op = 8'($urandom_range(0, 255));
        end
        span = FRAME_OVERHEAD + r_len;
        if (span > FRAME_CAP + 1) begin
          span = FRAME_CAP + 1;
        end
        tp = $urandom_range(1, span - 1);
        tn = 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          flaw = FL_NONE;
        end else if (pick < 78) begin
          flaw = FL_XOR;
        end else if (pick < 86) begin
          flaw = FL_FOOTER;
        end else if (pick < 94) begin
          // late only where the tick run stays short
          flaw = (timeout_reg <= 1000) ? FL_LATE : FL_NONE;
        end else begin
          // idle noise between frames: ticks and non-header bytes
          repeat ($urandom_range(1, 4)) begin
            noise = 8'($urandom_range(0, 255));
            if (noise == HEADER_BYTE) begin
              noise = 8'h00;
            end
            push_request(logic'($urandom_range(0, 1)), noise);
          end
          continue;
        end
        if (flaw == FL_LATE) begin
          tn = timeout_reg + 1 + $urandom_range(0, 3);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 5 && timeout_reg <= 1000) begin
            tn = timeout_reg;
          end else if (pick < 35) begin
            tn = $urandom_range(0, (timeout_reg < 20) ? timeout_reg : 20);
          end
        end
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), r_op,
                   8'($urandom_range(0, 255)), r_len, flaw, tp, tn);
      end
    end

    // Stop offering requests, drain the results, then let the pipeline settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sfrx_pkg.sv
src/sfrx_ctrl.sv
src/sfrx_dp.sv
src/serial_frame_receiver_xor_check_unit.sv
sim/tb.sv
